>>> rtl/core/ppid_pkg.sv
// Shared types, constants and the control store of the positional PID unit.
package ppid_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ERR_W     = SAMPLE_W + 1;
  localparam int SLOPE_W   = SAMPLE_W + 2;
  localparam int INT_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int ALPHA_W   = 17;
  localparam int FS_W      = 34;
  localparam int HALF_W    = FS_W / 2;
  localparam int MA_W      = ALPHA_W + 1;
  localparam int MB_W      = INT_W;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ACC_W     = 52;
  localparam int RAW_W     = 34;
  localparam int GAIN_FRAC = 8;
  localparam int FS_FRAC   = 16;
  localparam int ADDR_W    = 5;
  localparam int CFG_W     = INT_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FS_FRAC;

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_OUT_UPPER = 3'd3,
    REG_OUT_LOWER = 3'd4,
    REG_SUM_UPPER = 3'd5,
    REG_SUM_LOWER = 3'd6,
    REG_ALPHA     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    FN_PID   = 3'd0,
    FN_PD    = 3'd1,
    FN_AW    = 3'd2,
    FN_FILT  = 3'd3,
    FN_RESET = 3'd4
  } func_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic signed [SAMPLE_W-1:0] out_upper;
    logic signed [SAMPLE_W-1:0] out_lower;
    logic signed [INT_W-1:0]    sum_upper;
    logic signed [INT_W-1:0]    sum_lower;
    logic [ALPHA_W-1:0]         alpha;
  } cfg_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MS_NONE, MS_PE, MS_II, MS_DS, MS_AH, MS_AL, MS_CS, MS_DH, MS_DL
  } mul_sel_t;

  typedef enum logic [2:0] {
    AC_HOLD, AC_LOAD, AC_LOADHI, AC_ADD, AC_SHADD
  } acc_op_t;

  typedef enum logic [1:0] {
    RW_HOLD, RW_CLR, RW_ADD_G, RW_ADD_F
  } raw_op_t;

  typedef enum logic [1:0] {
    IN_NONE, IN_PLAIN, IN_AW
  } int_op_t;

  typedef enum logic [1:0] {
    ST_NONE, ST_SAVE, ST_CLEAR
  } st_op_t;

  typedef enum logic [1:0] {
    JP_NEXT, JP_GO, JP_IF_NOT_AW
  } jmp_t;

  typedef struct packed {
    mul_sel_t            mul;
    acc_op_t             acc;
    raw_op_t             raw;
    int_op_t             intg;
    st_op_t              st;
    jmp_t                jmp;
    logic                fs_wr;
    logic                zero;
    logic                fin;
    logic [ADDR_W-1:0]   target;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{mul: MS_NONE, acc: AC_HOLD, raw: RW_HOLD, intg: IN_NONE,
                               st: ST_NONE, jmp: JP_NEXT, fs_wr: 1'b0, zero: 1'b0,
                               fin: 1'b0, target: '0};

  // program entry points
  localparam logic [ADDR_W-1:0] UA_PID  = 5'd0;
  localparam logic [ADDR_W-1:0] UA_AW   = 5'd1;
  localparam logic [ADDR_W-1:0] UA_FIN  = 5'd8;
  localparam logic [ADDR_W-1:0] UA_PD   = 5'd9;
  localparam logic [ADDR_W-1:0] UA_FILT = 5'd13;
  localparam logic [ADDR_W-1:0] UA_RST  = 5'd22;
  localparam logic [ADDR_W-1:0] UA_NOP  = 5'd23;

  function automatic logic [ADDR_W-1:0] entry(input logic [2:0] f);
    logic [ADDR_W-1:0] a;
    case (f)
      FN_PID:   a = UA_PID;
      FN_PD:    a = UA_PD;
      FN_AW:    a = UA_AW;
      FN_FILT:  a = UA_FILT;
      FN_RESET: a = UA_RST;
      default:  a = UA_NOP;
    endcase
    return a;
  endfunction

  // Control store. A product is registered for the step after its mul field,
  // the accumulator for the step after that, the raw sum for the step after that.
  function automatic ctl_t ucode(input logic [ADDR_W-1:0] addr);
    ctl_t c;
    c = CTL_NOP;
    case (addr)
      UA_PID: c.intg = IN_PLAIN;
      UA_AW: begin
        c.mul = MS_PE;
        c.raw = RW_CLR;
      end
      UA_AW + 5'd1: begin
        c.mul = MS_II;
        c.acc = AC_LOAD;
      end
      UA_AW + 5'd2: begin
        c.mul = MS_DS;
        c.acc = AC_LOAD;
        c.raw = RW_ADD_G;
      end
      UA_AW + 5'd3: begin
        c.acc = AC_LOAD;
        c.raw = RW_ADD_G;
      end
      UA_AW + 5'd4: c.raw = RW_ADD_G;
      UA_AW + 5'd5: begin
        c.jmp    = JP_IF_NOT_AW;
        c.target = UA_FIN;
      end
      UA_AW + 5'd6: c.intg = IN_AW;
      UA_FIN: begin
        c.fin = 1'b1;
        c.st  = ST_SAVE;
      end
      UA_PD: begin
        c.mul = MS_PE;
        c.raw = RW_CLR;
      end
      UA_PD + 5'd1: begin
        c.mul = MS_DS;
        c.acc = AC_LOAD;
      end
      UA_PD + 5'd2: begin
        c.acc = AC_LOAD;
        c.raw = RW_ADD_G;
      end
      UA_PD + 5'd3: begin
        c.raw    = RW_ADD_G;
        c.jmp    = JP_GO;
        c.target = UA_FIN;
      end
      UA_FILT: begin
        c.intg = IN_PLAIN;
        c.mul  = MS_AH;
        c.raw  = RW_CLR;
      end
      UA_FILT + 5'd1: begin
        c.mul = MS_AL;
        c.acc = AC_LOADHI;
      end
      UA_FILT + 5'd2: begin
        c.mul = MS_CS;
        c.acc = AC_ADD;
      end
      UA_FILT + 5'd3: begin
        c.mul = MS_PE;
        c.acc = AC_SHADD;
      end
      UA_FILT + 5'd4: begin
        c.mul   = MS_II;
        c.acc   = AC_LOAD;
        c.fs_wr = 1'b1;
      end
      UA_FILT + 5'd5: begin
        c.mul = MS_DH;
        c.acc = AC_LOAD;
        c.raw = RW_ADD_G;
      end
      UA_FILT + 5'd6: begin
        c.mul = MS_DL;
        c.acc = AC_LOADHI;
        c.raw = RW_ADD_G;
      end
      UA_FILT + 5'd7: c.acc = AC_ADD;
      UA_FILT + 5'd8: begin
        c.raw    = RW_ADD_F;
        c.jmp    = JP_GO;
        c.target = UA_FIN;
      end
      UA_RST: begin
        c.fin  = 1'b1;
        c.zero = 1'b1;
        c.st   = ST_CLEAR;
      end
      UA_NOP: begin
        c.fin  = 1'b1;
        c.zero = 1'b1;
      end
      default: begin
        c.fin  = 1'b1;
        c.zero = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/ppid_datapath.sv
// Datapath of the PID unit: shared multiplier, accumulator, integrator and state.
module ppid_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ppid_pkg::cfg_t                       cfg,
  input  logic                                 ld,
  input  logic signed [ppid_pkg::SAMPLE_W-1:0] ld_setpoint,
  input  logic signed [ppid_pkg::SAMPLE_W-1:0] ld_measured,
  input  ppid_pkg::ctl_t                       ctl,
  output logic signed [ppid_pkg::SAMPLE_W-1:0] drive
);

  localparam int ERR_W  = ppid_pkg::ERR_W;
  localparam int SLP_W  = ppid_pkg::SLOPE_W;
  localparam int INT_W  = ppid_pkg::INT_W;
  localparam int FS_W   = ppid_pkg::FS_W;
  localparam int HALF_W = ppid_pkg::HALF_W;
  localparam int MA_W   = ppid_pkg::MA_W;
  localparam int MB_W   = ppid_pkg::MB_W;
  localparam int PROD_W = ppid_pkg::PROD_W;
  localparam int ACC_W  = ppid_pkg::ACC_W;
  localparam int RAW_W  = ppid_pkg::RAW_W;
  localparam int SW     = ppid_pkg::SAMPLE_W;
  localparam int GW     = ppid_pkg::GAIN_W;

  logic signed [ERR_W-1:0]  e_r, prev_r, e_ld;
  logic signed [SLP_W-1:0]  slope_r;
  logic signed [INT_W-1:0]  integ_r, integ_nxt;
  logic signed [FS_W-1:0]   fs_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [RAW_W-1:0]  raw_r, raw_nxt;

  logic [ppid_pkg::ALPHA_W-1:0] alpha_sat, alpha_inv;
  logic signed [MA_W-1:0]       ma;
  logic signed [MB_W-1:0]       mb;
  logic signed [HALF_W-1:0]     fs_hi;
  logic signed [HALF_W:0]       fs_lo;
  logic signed [INT_W:0]        isum;
  logic signed [ERR_W-1:0]      e_add;
  logic                         raw_hi, raw_lo, ei_pos, ei_neg, add_ok;

  assign e_ld      = ERR_W'(ld_setpoint) - ERR_W'(ld_measured);
  assign alpha_sat = (cfg.alpha > ppid_pkg::ALPHA_ONE) ? ppid_pkg::ALPHA_ONE : cfg.alpha;
  assign alpha_inv = ppid_pkg::ALPHA_ONE - alpha_sat;
  assign fs_hi     = fs_r[FS_W-1:HALF_W];
  assign fs_lo     = signed'({1'b0, fs_r[HALF_W-1:0]});

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.mul)
      ppid_pkg::MS_PE: begin
        ma = MA_W'(cfg.gain_p);
        mb = MB_W'(e_r);
      end
      ppid_pkg::MS_II: begin
        ma = MA_W'(cfg.gain_i);
        mb = MB_W'(integ_r);
      end
      ppid_pkg::MS_DS: begin
        ma = MA_W'(cfg.gain_d);
        mb = MB_W'(slope_r);
      end
      ppid_pkg::MS_AH: begin
        ma = MA_W'(signed'({1'b0, alpha_sat}));
        mb = MB_W'(fs_hi);
      end
      ppid_pkg::MS_AL: begin
        ma = MA_W'(signed'({1'b0, alpha_sat}));
        mb = MB_W'(fs_lo);
      end
      ppid_pkg::MS_CS: begin
        ma = MA_W'(signed'({1'b0, alpha_inv}));
        mb = MB_W'(slope_r);
      end
      ppid_pkg::MS_DH: begin
        ma = MA_W'(cfg.gain_d);
        mb = MB_W'(fs_hi);
      end
      ppid_pkg::MS_DL: begin
        ma = MA_W'(cfg.gain_d);
        mb = MB_W'(fs_lo);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(ma) * PROD_W'(mb);

  always_comb begin
    case (ctl.acc)
      ppid_pkg::AC_LOAD:   acc_nxt = ACC_W'(prod_r);
      ppid_pkg::AC_LOADHI: acc_nxt = ACC_W'(prod_r) <<< HALF_W;
      ppid_pkg::AC_ADD:    acc_nxt = acc_r + ACC_W'(prod_r);
      ppid_pkg::AC_SHADD:  acc_nxt = (acc_r >>> ppid_pkg::FS_FRAC) + ACC_W'(prod_r);
      default:             acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    case (ctl.raw)
      ppid_pkg::RW_CLR:   raw_nxt = '0;
      ppid_pkg::RW_ADD_G: raw_nxt = raw_r + RAW_W'(acc_r >>> ppid_pkg::GAIN_FRAC);
      ppid_pkg::RW_ADD_F:
        raw_nxt = raw_r + RAW_W'(acc_r >>> (ppid_pkg::FS_FRAC + ppid_pkg::GAIN_FRAC));
      default:            raw_nxt = raw_r;
    endcase
  end

  // saturation of the unclamped sum, shared by the output clamp and anti-windup
  assign raw_hi = raw_r > RAW_W'(cfg.out_upper);
  assign raw_lo = raw_r < RAW_W'(cfg.out_lower);

  // sign of e * gain_i without forming the product
  assign ei_pos = (e_r != '0) && (cfg.gain_i != '0) && (e_r[ERR_W-1] == cfg.gain_i[GW-1]);
  assign ei_neg = (e_r != '0) && (cfg.gain_i != '0) && (e_r[ERR_W-1] != cfg.gain_i[GW-1]);

  always_comb begin
    if (raw_hi)
      add_ok = !ei_pos;
    else if (raw_lo)
      add_ok = !ei_neg;
    else
      add_ok = 1'b1;
  end

  assign e_add = (ctl.intg == ppid_pkg::IN_PLAIN || add_ok) ? e_r : '0;
  assign isum  = (INT_W+1)'(integ_r) + (INT_W+1)'(e_add);

  always_comb begin
    if (isum > (INT_W+1)'(cfg.sum_upper))
      integ_nxt = cfg.sum_upper;
    else if (isum < (INT_W+1)'(cfg.sum_lower))
      integ_nxt = cfg.sum_lower;
    else
      integ_nxt = isum[INT_W-1:0];
  end

  always_comb begin
    if (ctl.zero)
      drive = '0;
    else if (raw_hi)
      drive = cfg.out_upper;
    else if (raw_lo)
      drive = cfg.out_lower;
    else
      drive = raw_r[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      e_r     <= e_ld;
      slope_r <= SLP_W'(e_ld) - SLP_W'(prev_r);
    end
    if (ctl.mul != ppid_pkg::MS_NONE)
      prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    raw_r <= raw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
      fs_r    <= '0;
    end else begin
      if (ctl.st == ppid_pkg::ST_CLEAR) begin
        prev_r  <= '0;
        integ_r <= '0;
      end else begin
        if (ctl.st == ppid_pkg::ST_SAVE)
          prev_r <= e_r;
        if (ctl.intg != ppid_pkg::IN_NONE)
          integ_r <= integ_nxt;
      end
      if (ctl.fs_wr)
        fs_r <= FS_W'(acc_r);
    end
  end

endmodule

>>> rtl/core/positional_pid_multi_mode_unit.sv
// Top level of the positional PID unit: channels, configuration and microsequencer.
//
//  channel | dir | ports                            | transaction carries
//  --------+-----+----------------------------------+-------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata     | setpoint, measured; func in tuser
//  out     | out | out_tvalid/out_tready/out_tdata  | drive
//  cfg     | in  | cfg_valid/cfg_ready              | register index, write data
//
// One multiplier is shared by all gain and filter products, stepped by the control
// store; reset and unused selectors go straight to the final step, and an item is
// accepted only in the idle state. The next item is taken while the output
// register still holds a result; the final step waits only when that register is
// full and not drained. Reset (rst_n, synchronous) loads the register defaults and
// clears the error history, integral and filtered slope.
module positional_pid_multi_mode_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // [15:0] setpoint, [31:16] measured
  input  logic [2:0]                         in_tuser,   // [2:0] func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] drive
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [ppid_pkg::CFG_W-1:0]         cfg_data
);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t                         state_r;
  logic [ppid_pkg::ADDR_W-1:0]    pc_r, pc_nxt;
  logic [2:0]                     func_r;
  logic                           out_tvalid_r;
  logic [15:0]                    out_tdata_r;
  ppid_pkg::cfg_t                 cfg_r;
  ppid_pkg::ctl_t                 ctl_rom, ctl;
  logic                           in_acc, out_free, run, take;
  logic signed [15:0]             drive;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  assign ctl_rom  = ppid_pkg::ucode(pc_r);
  assign out_free = !out_tvalid_r || out_tready;
  assign run      = (state_r == S_RUN) && (!ctl_rom.fin || out_free);
  assign ctl      = run ? ctl_rom : ppid_pkg::CTL_NOP;

  always_comb begin
    case (ctl_rom.jmp)
      ppid_pkg::JP_GO:        take = 1'b1;
      ppid_pkg::JP_IF_NOT_AW: take = (func_r != ppid_pkg::FN_AW);
      default:                take = 1'b0;
    endcase
    pc_nxt = take ? ctl_rom.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      func_r       <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      // a new result may replace one that drains at the same edge
      if (run && ctl_rom.fin) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= drive;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_RUN;
            pc_r    <= ppid_pkg::entry(in_tuser);
            func_r  <= in_tuser;
          end
        end
        S_RUN: begin
          if (run) begin
            if (ctl_rom.fin)
              state_r <= S_IDLE;
            else
              pc_r <= pc_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= '0;
      cfg_r.gain_i    <= '0;
      cfg_r.gain_d    <= '0;
      cfg_r.out_upper <= 16'sh7FFF;
      cfg_r.out_lower <= 16'sh8000;
      cfg_r.sum_upper <= 24'sd1000;
      cfg_r.sum_lower <= -24'sd1000;
      cfg_r.alpha     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppid_pkg::REG_GAIN_P:    cfg_r.gain_p    <= cfg_data[15:0];
        ppid_pkg::REG_GAIN_I:    cfg_r.gain_i    <= cfg_data[15:0];
        ppid_pkg::REG_GAIN_D:    cfg_r.gain_d    <= cfg_data[15:0];
        ppid_pkg::REG_OUT_UPPER: cfg_r.out_upper <= cfg_data[15:0];
        ppid_pkg::REG_OUT_LOWER: cfg_r.out_lower <= cfg_data[15:0];
        ppid_pkg::REG_SUM_UPPER: cfg_r.sum_upper <= cfg_data[23:0];
        ppid_pkg::REG_SUM_LOWER: cfg_r.sum_lower <= cfg_data[23:0];
        ppid_pkg::REG_ALPHA:     cfg_r.alpha     <= cfg_data[ppid_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  ppid_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .ld          (in_acc),
    .ld_setpoint (in_tdata[15:0]),
    .ld_measured (in_tdata[31:16]),
    .ctl         (ctl),
    .drive       (drive)
  );

endmodule

>>> rtl/core/ppid_checker.sv
// Port-level checks of the PID unit, bound to the top level.
module ppid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a held result may not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in flight");

  // ready only drops because a transaction was taken
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("ready dropped without an input transaction");

  // a new result comes from a busy sequencer, which then frees the input
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("sequencer still busy after issuing a result");

endmodule

bind positional_pid_multi_mode_unit ppid_checker u_ppid_checker (.*);

>>> tb/tb_positional_pid_multi_mode_unit.sv
// Self-checking testbench for the positional PID unit: directed and random items against a predictor.
module tb_positional_pid_multi_mode_unit;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX    = 10;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 145;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [31:0]                in_tdata;
  logic [2:0]                 in_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [15:0]                out_tdata;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [2:0]                 cfg_index;
  logic [ppid_pkg::CFG_W-1:0] cfg_data;

  positional_pid_multi_mode_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // controller copy: register file and loop state
  longint kp, ki, kd, drive_hi, drive_lo, integ_hi, integ_lo, alpha_q;
  longint last_err, integ_sum, slope_lp;

  logic [15:0] drive_q[$];
  logic [15:0] want_drive;
  int          mismatches  = 0;
  int          cycle_count = 0;
  bit          quiet;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clip(longint v, longint hi, longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint gain_mul(longint g, longint x);
    return (g * x) >>> ppid_pkg::GAIN_FRAC;
  endfunction

  function automatic void reset_predictor();
    kp        = 0;
    ki        = 0;
    kd        = 0;
    drive_hi  = 32767;
    drive_lo  = -32768;
    integ_hi  = 1000;
    integ_lo  = -1000;
    alpha_q   = 0;
    last_err  = 0;
    integ_sum = 0;
    slope_lp  = 0;
  endfunction

  function automatic void load_reg(ppid_pkg::reg_idx_t idx, logic [ppid_pkg::CFG_W-1:0] d);
    case (idx)
      ppid_pkg::REG_GAIN_P:    kp       = longint'($signed(d[ppid_pkg::GAIN_W-1:0]));
      ppid_pkg::REG_GAIN_I:    ki       = longint'($signed(d[ppid_pkg::GAIN_W-1:0]));
      ppid_pkg::REG_GAIN_D:    kd       = longint'($signed(d[ppid_pkg::GAIN_W-1:0]));
      ppid_pkg::REG_OUT_UPPER: drive_hi = longint'($signed(d[ppid_pkg::SAMPLE_W-1:0]));
      ppid_pkg::REG_OUT_LOWER: drive_lo = longint'($signed(d[ppid_pkg::SAMPLE_W-1:0]));
      ppid_pkg::REG_SUM_UPPER: integ_hi = longint'($signed(d));
      ppid_pkg::REG_SUM_LOWER: integ_lo = longint'($signed(d));
      ppid_pkg::REG_ALPHA:     alpha_q  = longint'(d[ppid_pkg::ALPHA_W-1:0]);
      default: ;
    endcase
  endfunction

  // Drive for one item; advances error history, integral and filtered slope.
  function automatic logic [15:0] pid_drive_next(logic [2:0] fn,
                                                 logic signed [ppid_pkg::SAMPLE_W-1:0] sp,
                                                 logic signed [ppid_pkg::SAMPLE_W-1:0] fb);
    longint err, dslope, raw, a, one, ei;
    bit     grow;
    one    = longint'(ppid_pkg::ALPHA_ONE);
    err    = longint'(sp) - longint'(fb);
    dslope = err - last_err;
    case (fn)
      ppid_pkg::FN_PID: begin
        integ_sum = clip(integ_sum + err, integ_hi, integ_lo);
        raw = gain_mul(kp, err) + gain_mul(ki, integ_sum) + gain_mul(kd, dslope);
      end
      ppid_pkg::FN_PD: raw = gain_mul(kp, err) + gain_mul(kd, dslope);
      ppid_pkg::FN_AW: begin
        // output taken from the old integral; in saturation integrate only an error that pulls back
        raw = gain_mul(kp, err) + gain_mul(ki, integ_sum) + gain_mul(kd, dslope);
        ei  = err * ki;
        if (raw > drive_hi) grow = (ei <= 0);
        else if (raw < drive_lo) grow = (ei >= 0);
        else grow = 1'b1;
        if (grow) integ_sum = integ_sum + err;
        integ_sum = clip(integ_sum, integ_hi, integ_lo);
      end
      ppid_pkg::FN_FILT: begin
        a = (alpha_q > one) ? one : alpha_q;
        integ_sum = clip(integ_sum + err, integ_hi, integ_lo);
        slope_lp  = (a * slope_lp + (one - a) * dslope * one) >>> ppid_pkg::FS_FRAC;
        raw = gain_mul(kp, err) + gain_mul(ki, integ_sum)
            + ((kd * slope_lp) >>> (ppid_pkg::FS_FRAC + ppid_pkg::GAIN_FRAC));
      end
      ppid_pkg::FN_RESET: begin
        // filtered slope survives a state reset
        last_err  = 0;
        integ_sum = 0;
        return '0;
      end
      default: return '0;
    endcase
    last_err = err;
    return 16'(clip(raw, drive_hi, drive_lo));
  endfunction

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    if (mismatches < REPORT_MAX)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic send_item(logic [2:0] fn, logic signed [ppid_pkg::SAMPLE_W-1:0] sp,
                           logic signed [ppid_pkg::SAMPLE_W-1:0] fb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {fb, sp};
    do @(posedge clk); while (!in_tready);
    drive_q.push_back(pid_drive_next(fn, sp, fb));
    @(negedge clk);
  endtask

  task automatic write_reg(ppid_pkg::reg_idx_t idx, longint value);
    logic [ppid_pkg::CFG_W-1:0] d;
    d = ppid_pkg::CFG_W'($urandom);  // junk above the register width
    case (idx)
      ppid_pkg::REG_SUM_UPPER, ppid_pkg::REG_SUM_LOWER: d = ppid_pkg::CFG_W'(value);
      ppid_pkg::REG_ALPHA: d[ppid_pkg::ALPHA_W-1:0] = ppid_pkg::ALPHA_W'(value);
      default:             d[ppid_pkg::GAIN_W-1:0]  = ppid_pkg::GAIN_W'(value);
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    load_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic apply_settings(longint p, longint i, longint dg, longint oh, longint ol,
                                longint sh, longint sl, longint al);
    write_reg(ppid_pkg::REG_GAIN_P, p);
    write_reg(ppid_pkg::REG_GAIN_I, i);
    write_reg(ppid_pkg::REG_GAIN_D, dg);
    write_reg(ppid_pkg::REG_OUT_UPPER, oh);
    write_reg(ppid_pkg::REG_OUT_LOWER, ol);
    write_reg(ppid_pkg::REG_SUM_UPPER, sh);
    write_reg(ppid_pkg::REG_SUM_LOWER, sl);
    write_reg(ppid_pkg::REG_ALPHA, al);
    cfg_valid <= 1'b0;
  endtask

  // block idle: every drive returned, plus a margin for the sequencer
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic longint rand_gain();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 32767)) - 16384;
      1: return longint'($signed(16'($urandom)));
      2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return longint'($urandom_range(0, 1024)) - 512;
    endcase
  endfunction

  // reset register values, all selectors, full-scale error both ways
  task automatic test_default_regs();
    for (int f = 0; f < 8; f++)
      send_item(3'(f), f[0] ? 16'sh7FFF : 16'sh8000, f[0] ? 16'sh8000 : 16'sh7FFF);
  endtask

  task automatic test_windup_and_clamps();
    wait_idle();
    apply_settings(256, 256, 256, 500, -500, 3000, -3000, 16384);
    send_item(ppid_pkg::FN_PID, 16'sd2000, 16'sd0);
    send_item(ppid_pkg::FN_PID, 16'sd2000, 16'sd0);    // integral hits upper clamp
    send_item(ppid_pkg::FN_AW, 16'sd100, 16'sd0);      // saturated high, error pushes further: hold
    send_item(ppid_pkg::FN_AW, -16'sd100, 16'sd0);     // saturated high, error pulls back: integrate
    send_item(ppid_pkg::FN_PD, 16'sd10, 16'sd0);       // integral untouched
    send_item(ppid_pkg::FN_RESET, 16'sd0, 16'sd0);
    send_item(ppid_pkg::FN_PID, -16'sd2000, 16'sd0);
    send_item(ppid_pkg::FN_PID, -16'sd2000, 16'sd0);   // lower clamp
    send_item(ppid_pkg::FN_AW, -16'sd50, 16'sd0);      // saturated low: hold
    send_item(ppid_pkg::FN_AW, 16'sd50, 16'sd0);       // saturated low, recovering: integrate
    send_item(ppid_pkg::FN_FILT, 16'sd300, 16'sd0);
    send_item(ppid_pkg::FN_FILT, 16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_filter_alpha();
    wait_idle();
    apply_settings(0, 0, 32767, 32767, -32768, 1000, -1000, longint'(ppid_pkg::ALPHA_ONE));
    send_item(ppid_pkg::FN_FILT, 16'sd1000, 16'sd0);   // weight of one keeps the old slope
    wait_idle();
    apply_settings(0, 0, 32767, 32767, -32768, 1000, -1000, 131071);  // saturates to one
    send_item(ppid_pkg::FN_FILT, -16'sd1000, 16'sd0);
    send_item(ppid_pkg::FN_RESET, 16'sd0, 16'sd0);
    send_item(ppid_pkg::FN_FILT, -16'sd1000, 16'sd0);  // slope kept across reset
    wait_idle();
    apply_settings(0, 0, 32767, 32767, -32768, 1000, -1000, 0);
    send_item(ppid_pkg::FN_FILT, 16'sd500, 16'sd0);
  endtask

  task automatic send_random_item();
    int                                    r;
    logic [2:0]                            fn;
    logic signed [ppid_pkg::SAMPLE_W-1:0]  sp, fb;
    r = $urandom_range(0, 99);
    if (r < 22) fn = ppid_pkg::FN_PID;
    else if (r < 40) fn = ppid_pkg::FN_PD;
    else if (r < 66) fn = ppid_pkg::FN_AW;
    else if (r < 93) fn = ppid_pkg::FN_FILT;
    else if (r < 97) fn = ppid_pkg::FN_RESET;
    else fn = 3'(ppid_pkg::FN_RESET) + 3'($urandom_range(1, 3));
    sp = 16'($urandom);
    // mostly small errors so that the loop spends time out of saturation
    if ($urandom_range(0, 9) < 7) fb = sp - 16'($urandom_range(0, 400)) + 16'sd200;
    else fb = 16'($urandom);
    send_item(fn, sp, fb);
  endtask

  task automatic test_random_phases();
    longint oh, ol, sh, sl, al, tmp;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      quiet = (ph == PHASES - 1);
      case (ph)
        0: apply_settings(-32768, 32767, -32768, 32767, -32768, 8388607, -8388608,
                          longint'(ppid_pkg::ALPHA_ONE));
        1: apply_settings(32767, -32768, 32767, -32768, 32767, -8388608, 8388607, 131071);
        default: begin
          oh = longint'($signed(16'($urandom)));
          ol = longint'($signed(16'($urandom)));
          if (ol > oh && $urandom_range(0, 5) != 0) begin
            tmp = oh;
            oh  = ol;
            ol  = tmp;
          end
          if ($urandom_range(0, 2) == 0) begin
            sh = longint'($signed(24'($urandom)));
            sl = longint'($signed(24'($urandom)));
          end else begin
            sh = $urandom_range(0, 20000);
            sl = -longint'($urandom_range(0, 20000));
          end
          if ($urandom_range(0, 4) == 0) al = $urandom_range(0, 131071);
          else al = $urandom_range(0, 65536);
          apply_settings(rand_gain(), rand_gain(), rand_gain(), oh, ol, sh, sl, al);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end
  endtask

  // result side back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_q.size() == 0) begin
        note_mismatch("unexpected drive transaction", 'x, out_tdata);
      end else begin
        want_drive = drive_q.pop_front();
        if (out_tdata !== want_drive) note_mismatch("drive", want_drive, out_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    reset_predictor();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_regs();
    test_windup_and_clamps();
    test_filter_alpha();
    test_random_phases();

    wait_idle();
    if (mismatches == 0 && drive_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
